// ===== design/sjpc_pkg.sv =====
// ----------------------------------------------------------------------------
// sjpc_pkg: shared types and constants of the stepper jog pulse controller
// Holds the operation codes, the sequencer states, the divider status group
// and the field widths, reset values and fixed geometry and timing constants.
// ----------------------------------------------------------------------------
package sjpc_pkg;

	// Field widths.
	localparam int OP_W    = 3;
	localparam int SPEED_W = 16;
	localparam int STEPS_W = 24;
	localparam int POS_W   = 13;
	localparam int DIST_W  = 12;
	localparam int TICKS_W = 20;

	// Geometry and timing.
	localparam int STEPS_PER_TURN   = 8000;
	localparam int TICKS_PER_SECOND = 1000000;
	localparam int HALF_TURN        = STEPS_PER_TURN / 2;

	localparam logic [POS_W-1:0] POS_LAST = POS_W'(STEPS_PER_TURN - 1);
	localparam logic [POS_W-1:0] POS_TURN = POS_W'(STEPS_PER_TURN);

	// Signed forms used by the shortest-path computation.
	localparam int AIM_W = POS_W + 1;
	localparam logic signed [AIM_W-1:0] AIM_TURN     = AIM_W'(STEPS_PER_TURN);
	localparam logic signed [AIM_W-1:0] AIM_HALF     = AIM_W'(HALF_TURN);
	localparam logic signed [AIM_W-1:0] AIM_NEG_HALF = -AIM_W'(HALF_TURN);

	// Register reset values.
	localparam logic [SPEED_W-1:0] MIN_SPEED_RST = 16'd50;
	localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 16'd1200;

	// Configuration register indexes.
	localparam logic CFG_MIN_SPEED = 1'b0;
	localparam logic CFG_MAX_SPEED = 1'b1;

	// Divider geometry: one quotient bit per pass.
	localparam int DIV_STEPS = TICKS_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam logic [TICKS_W-1:0] DIVIDEND = TICKS_W'(TICKS_PER_SECOND);

	typedef enum logic [OP_W-1:0] {
		OP_TICK  = 3'd0,
		OP_START = 3'd1,
		OP_JOG   = 3'd2,
		OP_STOP  = 3'd3,
		OP_AIM   = 3'd4
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_DIVIDE
	} seq_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// ===== design/sjpc_div.sv =====
// ----------------------------------------------------------------------------
// sjpc_div: iterative step interval divider
// Restoring division of the fixed tick rate by a 16-bit speed, one quotient
// bit per cycle through a single shared subtractor.
// ----------------------------------------------------------------------------
module sjpc_div
	import sjpc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [SPEED_W-1:0] divisor,
	output logic [TICKS_W-1:0] quotient,
	output div_status_t        status
);

	logic [SPEED_W-1:0] divisor_q;
	logic [SPEED_W-1:0] rem_q;
	logic [TICKS_W-1:0] dq_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [SPEED_W:0] shifted;
	logic [SPEED_W:0] trial;
	logic             fits;

	// The partial remainder stays below the divisor, so the shifted value
	// fits in one bit more than the divisor.
	assign shifted = {rem_q, dq_q[TICKS_W-1]};
	assign trial   = shifted - {1'b0, divisor_q};
	assign fits    = shifted >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			divisor_q <= divisor;
			rem_q     <= '0;
			dq_q      <= DIVIDEND;
		end else if (busy_q) begin
			rem_q <= fits ? trial[SPEED_W-1:0] : shifted[SPEED_W-1:0];
			dq_q  <= {dq_q[TICKS_W-2:0], fits};
		end
	end

	assign quotient    = dq_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

// ===== design/stepper_jog_pulse_controller_unit.sv =====
// ----------------------------------------------------------------------------
// stepper_jog_pulse_controller_unit: step and direction generator
// Tracks position, direction, jog countdown and step timing of a stepper
// motor, one request per operation, with an iterative interval divider.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake          Contents
// cfg      in         cfg_wr_en          cfg_index selects min or max speed
// s        in         s_tvalid/s_tready  op, clockwise, speed, steps, target
// m        out        m_tvalid/m_tready  step, direction, position, status
//
// Ticks, stops, unused operations, a jog of zero steps and an aim that is
// already on target have their result registered at the edge that accepts
// the request. Start, jog and aim requests need a new step interval, which
// the shared subtractor builds one bit per cycle; their result is registered
// once the divider reports done, and no new request is taken before then.
// A new request is taken while the block is idle and the output register
// is empty or being emptied. Reset puts the motor stopped, clockwise, at
// position zero, with the speed limits at 50 and 1200 steps per second.
//
module stepper_jog_pulse_controller_unit
	import sjpc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// Configuration write port.
	input  logic               cfg_wr_en,
	input  logic               cfg_index,
	input  logic [SPEED_W-1:0] cfg_data,
	// Requests: op[2:0], clockwise[3], speed[19:4], jog_steps[43:20],
	// target_position[56:44], zero fill above.
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [63:0]        s_tdata,
	// Results: step_pulse[0], direction_cw[1], position[14:2],
	// is_running[15], steps_remaining[39:16], jog_done[40],
	// aim_distance[52:41], zero fill above.
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [55:0]        m_tdata
);

	// Request fields.
	logic [OP_W-1:0]    in_op;
	logic               in_cw;
	logic [SPEED_W-1:0] in_speed;
	logic [STEPS_W-1:0] in_steps;
	logic [POS_W-1:0]   in_target;

	assign in_op     = s_tdata[2:0];
	assign in_cw     = s_tdata[3];
	assign in_speed  = s_tdata[19:4];
	assign in_steps  = s_tdata[43:20];
	assign in_target = s_tdata[56:44];

	// Configuration registers.
	logic [SPEED_W-1:0] min_speed_q;
	logic [SPEED_W-1:0] max_speed_q;

	// Motor state.
	logic               running_q;
	logic               dir_cw_q;
	logic [TICKS_W-1:0] interval_q;
	logic [STEPS_W-1:0] jog_left_q;
	logic [POS_W-1:0]   pos_q;
	logic [TICKS_W-1:0] elapsed_q;

	// Motion waiting for its interval.
	logic               pend_cw_q;
	logic [STEPS_W-1:0] pend_steps_q;
	logic [DIST_W-1:0]  pend_dist_q;

	// Output register.
	logic               m_tvalid_q;
	logic [55:0]        m_tdata_q;

	seq_state_t state_q;
	seq_state_t state_d;

	logic accept;
	logic div_start;
	logic [TICKS_W-1:0] div_quotient;
	div_status_t div_status;

	assign accept = s_tvalid && s_tready;

	// ------------------------------------------------------------------
	// Speed clamp. Min is checked first, so a min above max still wins
	// for low speeds. A clamped speed of zero divides as one.
	// ------------------------------------------------------------------
	logic [SPEED_W-1:0] speed_clamped;
	logic [SPEED_W-1:0] divisor;

	always_comb begin
		if (in_speed < min_speed_q) begin
			speed_clamped = min_speed_q;
		end else if (in_speed > max_speed_q) begin
			speed_clamped = max_speed_q;
		end else begin
			speed_clamped = in_speed;
		end
		divisor = (speed_clamped == '0) ? SPEED_W'(1) : speed_clamped;
	end

	// ------------------------------------------------------------------
	// Tick path: saturating elapsed counter, step decision, position wrap
	// and jog countdown.
	// ------------------------------------------------------------------
	logic [TICKS_W-1:0] elapsed_inc;
	logic               fire;
	logic [POS_W-1:0]   pos_stepped;
	logic               jog_ends;

	always_comb begin
		elapsed_inc = (elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q;
		fire = running_q && (interval_q != '0) && (elapsed_inc >= interval_q);
		if (dir_cw_q) begin
			pos_stepped = (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
		end else begin
			pos_stepped = (pos_q == '0) ? POS_LAST : pos_q - 1'b1;
		end
		jog_ends = (jog_left_q == STEPS_W'(1));
	end

	// ------------------------------------------------------------------
	// Aim path: shortest wrapped difference to the target. Exactly half a
	// turn keeps its sign.
	// ------------------------------------------------------------------
	logic [POS_W-1:0]        target_mod;
	logic signed [AIM_W-1:0] diff_raw;
	logic signed [AIM_W-1:0] diff;
	logic signed [AIM_W-1:0] diff_abs;
	logic [DIST_W-1:0]       aim_mag;
	logic                    aim_cw;
	logic                    aim_moves;

	always_comb begin
		target_mod = (in_target >= POS_TURN) ? in_target - POS_TURN : in_target;
		diff_raw   = $signed({1'b0, target_mod}) - $signed({1'b0, pos_q});
		if (diff_raw > AIM_HALF) begin
			diff = diff_raw - AIM_TURN;
		end else if (diff_raw < AIM_NEG_HALF) begin
			diff = diff_raw + AIM_TURN;
		end else begin
			diff = diff_raw;
		end
		diff_abs  = diff[AIM_W-1] ? -diff : diff;
		aim_mag   = diff_abs[DIST_W-1:0];
		aim_cw    = !diff[AIM_W-1];
		aim_moves = (diff != '0);
	end

	// Requests that need a fresh interval go through the divider.
	logic needs_div;

	always_comb begin
		case (in_op)
			OP_START: needs_div = 1'b1;
			OP_JOG:   needs_div = (in_steps != '0);
			OP_AIM:   needs_div = aim_moves;
			default:  needs_div = 1'b0;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer.
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && needs_div) begin
					state_d = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (div_status.done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_IDLE:   s_tready = !m_tvalid_q || m_tready;
			ST_DIVIDE: s_tready = 1'b0;
			default:   s_tready = 1'b0;
		endcase
		div_start = accept && needs_div;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	sjpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (divisor),
		.quotient (div_quotient),
		.status   (div_status)
	);

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_speed_q <= MIN_SPEED_RST;
			max_speed_q <= MAX_SPEED_RST;
		end else if (cfg_wr_en) begin
			if (cfg_index == CFG_MIN_SPEED) begin
				min_speed_q <= cfg_data;
			end
			if (cfg_index == CFG_MAX_SPEED) begin
				max_speed_q <= cfg_data;
			end
		end
	end

	// Pending motion is captured at acceptance and committed when the
	// divider hands back the interval.
	always_ff @(posedge clk) begin
		if (div_start) begin
			if (in_op == OP_AIM) begin
				pend_cw_q    <= aim_cw;
				pend_steps_q <= STEPS_W'(aim_mag);
				pend_dist_q  <= aim_mag;
			end else begin
				pend_cw_q    <= in_cw;
				pend_steps_q <= (in_op == OP_JOG) ? in_steps : '0;
				pend_dist_q  <= '0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Motor state and output register. A new result takes the output
	// register; otherwise an accepted result empties it.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q  <= 1'b0;
			dir_cw_q   <= 1'b1;
			interval_q <= '0;
			jog_left_q <= '0;
			pos_q      <= '0;
			elapsed_q  <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (state_q == ST_DIVIDE && div_status.done) begin
				dir_cw_q   <= pend_cw_q;
				interval_q <= div_quotient;
				jog_left_q <= pend_steps_q;
				running_q  <= 1'b1;
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {3'b0, pend_dist_q, 1'b0, pend_steps_q, 1'b1,
					pos_q, pend_cw_q, 1'b0};
			end else if (accept && !needs_div) begin
				m_tvalid_q <= 1'b1;
				case (in_op)
					OP_TICK: begin
						if (fire) begin
							elapsed_q <= '0;
							pos_q     <= pos_stepped;
							if (jog_left_q != '0) begin
								jog_left_q <= jog_left_q - 1'b1;
							end
							m_tdata_q <= {3'b0, DIST_W'(0), jog_ends,
								(jog_left_q != '0) ? jog_left_q - 1'b1 : jog_left_q,
								running_q && !jog_ends, pos_stepped, dir_cw_q, 1'b1};
							if (jog_ends) begin
								running_q <= 1'b0;
							end
						end else begin
							elapsed_q <= elapsed_inc;
							m_tdata_q <= {3'b0, DIST_W'(0), 1'b0, jog_left_q,
								running_q, pos_q, dir_cw_q, 1'b0};
						end
					end
					OP_STOP: begin
						running_q  <= 1'b0;
						jog_left_q <= '0;
						m_tdata_q  <= {3'b0, DIST_W'(0), 1'b0, STEPS_W'(0),
							1'b0, pos_q, dir_cw_q, 1'b0};
					end
					default: begin
						m_tdata_q <= {3'b0, DIST_W'(0), 1'b0, jog_left_q,
							running_q, pos_q, dir_cw_q, 1'b0};
					end
				endcase
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIVIDE |-> !s_tready)
		else $error("request accepted while the interval divider is busy");

	a_div_start_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_status.busy)
		else $error("divider restarted while busy");

	a_done_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		div_status.done |=> m_tvalid_q)
		else $error("divider finished without a result");

	a_running_has_interval: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> interval_q != '0)
		else $error("motor running with a zero step interval");

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench for stepper_jog_pulse_controller_unit
// Drives operation requests through the request stream and rewrites the speed
// limits between test phases. A behavioral motor predictor works out the
// status that each request should return, and a checker compares every
// returned status field by field with the oldest prediction. Sender gaps and
// receiver stalls are varied from phase to phase.
// ----------------------------------------------------------------------------
module tb;
	import sjpc_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int MAX_REPORTS    = 10;
	localparam int DRAIN_CYCLES   = 30;

	// Operation codes that the block does not define; they must change nothing.
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	localparam logic [TICKS_W-1:0] ELAPSED_CEIL = '1;

	typedef struct {
		logic [OP_W-1:0]    op;
		logic               cw;
		logic [SPEED_W-1:0] speed;
		logic [STEPS_W-1:0] steps;
		logic [POS_W-1:0]   target;
	} motor_req_t;

	typedef struct {
		logic               step;
		logic               dir_cw;
		logic [POS_W-1:0]   pos;
		logic               running;
		logic [STEPS_W-1:0] steps_left;
		logic               jog_done;
		logic [DIST_W-1:0]  aim_dist;
	} motor_status_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_wr_en;
	logic               cfg_index;
	logic [SPEED_W-1:0] cfg_data;
	logic               s_tvalid;
	logic               s_tready;
	logic [63:0]        s_tdata;
	logic               m_tvalid;
	logic               m_tready;
	logic [55:0]        m_tdata;

	// Percent of cycles in which the sender holds back or the receiver stalls.
	int unsigned src_idle_pct   = 0;
	int unsigned sink_stall_pct = 0;

	int unsigned error_count  = 0;
	int unsigned results_seen = 0;
	int unsigned quiet_cycles = 0;

	// Predicted motor state and the speed limits it was computed with.
	logic [SPEED_W-1:0] lim_min;
	logic [SPEED_W-1:0] lim_max;
	logic               mdl_running;
	logic               mdl_cw;
	logic [TICKS_W-1:0] mdl_interval;
	logic [TICKS_W-1:0] mdl_elapsed;
	logic [STEPS_W-1:0] mdl_jog_left;
	logic [POS_W-1:0]   mdl_pos;

	// Status words still owed by the block, oldest first.
	motor_status_t status_due[$];

	stepper_jog_pulse_controller_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Motor predictor
	// ------------------------------------------------------------------------

	// Clamp order matters: the low limit is tested first, so with the limits
	// crossed a slow request gets the low limit and anything else the high one.
	function automatic logic [TICKS_W-1:0] interval_for_speed(logic [SPEED_W-1:0] req);
		int unsigned rate;
		rate = req;
		if (req < lim_min) rate = lim_min;
		else if (req > lim_max) rate = lim_max;
		if (rate == 0) rate = 1;
		return TICKS_W'(TICKS_PER_SECOND / rate);
	endfunction

	// Start, jog and aim all land here; none of them clears the tick counter.
	function automatic void start_motion(logic cw, logic [SPEED_W-1:0] req,
			logic [STEPS_W-1:0] count);
		mdl_cw       = cw;
		mdl_interval = interval_for_speed(req);
		mdl_jog_left = count;
		mdl_running  = 1'b1;
	endfunction

	function automatic motor_status_t advance_motor(motor_req_t r);
		motor_status_t s;
		int tgt;
		int diff;
		int magnitude;
		s.step     = 1'b0;
		s.jog_done = 1'b0;
		s.aim_dist = '0;
		case (r.op)
			OP_TICK: begin
				if (mdl_elapsed != ELAPSED_CEIL) mdl_elapsed++;
				if (mdl_running && mdl_interval != 0 && mdl_elapsed >= mdl_interval) begin
					mdl_elapsed = '0;
					s.step      = 1'b1;
					if (mdl_cw) mdl_pos = (mdl_pos == POS_LAST) ? '0 : mdl_pos + 1'b1;
					else mdl_pos = (mdl_pos == '0) ? POS_LAST : mdl_pos - 1'b1;
					if (mdl_jog_left != 0) begin
						mdl_jog_left--;
						if (mdl_jog_left == 0) begin
							mdl_running = 1'b0;
							s.jog_done  = 1'b1;
						end
					end
				end
			end
			OP_START: start_motion(r.cw, r.speed, '0);
			OP_JOG: begin
				if (r.steps != 0) start_motion(r.cw, r.speed, r.steps);
			end
			OP_STOP: begin
				mdl_running  = 1'b0;
				mdl_jog_left = '0;
			end
			OP_AIM: begin
				// Shortest wrapped path; exactly half a turn keeps its sign.
				tgt  = int'(r.target) % STEPS_PER_TURN;
				diff = tgt - int'(mdl_pos);
				if (diff > HALF_TURN) diff -= STEPS_PER_TURN;
				else if (diff < -HALF_TURN) diff += STEPS_PER_TURN;
				if (diff != 0) begin
					magnitude = (diff > 0) ? diff : -diff;
					start_motion(diff > 0, r.speed, STEPS_W'(magnitude));
					s.aim_dist = DIST_W'(magnitude);
				end
			end
			default: ;
		endcase
		s.dir_cw     = mdl_cw;
		s.pos        = mdl_pos;
		s.running    = mdl_running;
		s.steps_left = mdl_jog_left;
		return s;
	endfunction

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------

	// Holds valid until the block takes the request, then records the status
	// that the request must produce. Valid stays high into the next request
	// unless the sender decides to idle first.
	task automatic send_request(motor_req_t r);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, r.target, r.steps, r.speed, r.cw, r.op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		status_due.push_back(advance_motor(r));
	endtask

	task automatic send_op(logic [OP_W-1:0] op, logic cw, logic [SPEED_W-1:0] speed,
			logic [STEPS_W-1:0] steps, logic [POS_W-1:0] target);
		motor_req_t r;
		r.op     = op;
		r.cw     = cw;
		r.speed  = speed;
		r.steps  = steps;
		r.target = target;
		send_request(r);
	endtask

	// Fully random request content; speeds favor the two extremes.
	function automatic motor_req_t random_request();
		motor_req_t r;
		r.op = OP_W'($urandom);
		r.cw = 1'($urandom);
		case ($urandom_range(4))
			0: r.speed = '0;
			1: r.speed = '1;
			default: r.speed = SPEED_W'($urandom);
		endcase
		r.steps  = STEPS_W'($urandom);
		r.target = POS_W'($urandom);
		return r;
	endfunction

	// Lets every owed status come back; the block is idle after that.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (status_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_limits(logic [SPEED_W-1:0] lo, logic [SPEED_W-1:0] hi);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_MIN_SPEED;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= CFG_MAX_SPEED;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		lim_min = lo;
		lim_max = hi;
	endtask

	// Motion commands with random content, each followed by a burst of ticks
	// so that steps actually fire and short jogs and aims run to completion.
	// Most aims go to a spot a few steps from the predicted position so they
	// finish; the rest go anywhere, including targets past one turn.
	task automatic run_motion_mix(int unsigned n_items, int unsigned max_burst);
		motor_req_t  r;
		int unsigned sent;
		int unsigned pick;
		int unsigned burst;
		sent = 0;
		while (sent < n_items) begin
			r    = random_request();
			pick = $urandom_range(99);
			if (pick < 20) begin
				r.op = OP_START;
			end else if (pick < 55) begin
				r.op    = OP_JOG;
				r.steps = ($urandom_range(9) < 8) ? STEPS_W'($urandom_range(4, 1))
					: STEPS_W'($urandom);
			end else if (pick < 85) begin
				r.op = OP_AIM;
				if ($urandom_range(9) < 7)
					r.target = POS_W'((int'(mdl_pos) + STEPS_PER_TURN - 4
						+ int'($urandom_range(8))) % STEPS_PER_TURN);
			end else if (pick < 90) begin
				r.op = OP_STOP;
			end else if (pick < 95) begin
				r.op    = OP_JOG;
				r.steps = '0;
			end else begin
				r.op = OP_W'(OP_SPARE_LO + $urandom_range(OP_SPARE_HI - OP_SPARE_LO));
			end
			send_request(r);
			sent++;
			burst = $urandom_range(max_burst);
			repeat (burst) begin
				r    = random_request();
				r.op = OP_TICK;
				send_request(r);
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Runs at the reset limits from a stopped motor at position zero.
	task automatic test_directed_cases();
		logic [OP_W-1:0] code;
		send_op(OP_TICK, 1'b1, '0, '0, '0);           // tick with the motor stopped
		send_op(OP_AIM, 1'b0, '1, '1, '0);            // already on target
		send_op(OP_AIM, 1'b1, '1, '1, 13'd8000);      // one full turn is the same spot
		send_op(OP_JOG, 1'b0, '1, '0, '1);            // zero-step jog is ignored
		for (code = OP_SPARE_LO; code <= OP_SPARE_HI && code >= OP_SPARE_LO; code++)
			send_op(code, 1'b0, '1, '1, '1);
		send_op(OP_STOP, 1'b1, '1, '1, '1);
		send_op(OP_START, 1'b0, '0, '1, '0);          // below the low limit
		send_op(OP_START, 1'b1, '1, '0, '1);          // above the high limit
		send_op(OP_JOG, 1'b0, 16'd1200, '1, '0);      // longest jog
		send_op(OP_STOP, 1'b0, '0, '0, '0);
		send_op(OP_AIM, 1'b0, 16'd600, '0, 13'd4000); // exactly half a turn ahead
		send_op(OP_AIM, 1'b1, 16'd600, '0, 13'd4001); // just past half, goes back
		send_op(OP_AIM, 1'b0, '0, '0, '1);            // target beyond one turn
		send_op(OP_AIM, 1'b1, '1, '0, 13'd7999);      // one step backward over zero
		send_op(OP_STOP, 1'b1, '0, '0, '0);
		send_op(OP_TICK, 1'b0, '1, '1, '1);
	endtask

	// Highest possible step rate, no idling anywhere.
	task automatic test_fast_stepping();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		write_limits('1, '1);
		run_motion_mix(260, 60);
	endtask

	task automatic test_sender_gaps();
		src_idle_pct   = 75;
		sink_stall_pct = 0;
		write_limits(16'd20000, '1);
		run_motion_mix(220, 60);
	endtask

	// Limits from one to the highest speed; the receiver holds off most results.
	task automatic test_receiver_stalls();
		src_idle_pct   = 0;
		sink_stall_pct = 75;
		write_limits(16'd1, '1);
		run_motion_mix(220, 60);
	endtask

	// Low limit above the high limit.
	task automatic test_crossed_limits();
		src_idle_pct   = 17;
		sink_stall_pct = 17;
		write_limits('1, 16'd1);
		run_motion_mix(220, 60);
	endtask

	// Both limits at zero: every clamped speed is zero and divides as one.
	task automatic test_zero_limits();
		src_idle_pct   = 17;
		sink_stall_pct = 17;
		write_limits('0, '0);
		run_motion_mix(150, 30);
	endtask

	task automatic test_reset_limits();
		src_idle_pct   = 17;
		sink_stall_pct = 17;
		write_limits(MIN_SPEED_RST, MAX_SPEED_RST);
		run_motion_mix(240, 120);
	endtask

	// ------------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------------

	task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			if (error_count < MAX_REPORTS)
				$display("result %0d: %s expected %0h, got %0h", results_seen, field,
					want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		motor_status_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (status_due.size() == 0) begin
				if (error_count < MAX_REPORTS)
					$display("result %0d: no request is waiting for it, data %0h",
						results_seen, m_tdata);
				error_count++;
			end else begin
				want = status_due.pop_front();
				check_field("step_pulse", want.step, m_tdata[0]);
				check_field("direction_cw", want.dir_cw, m_tdata[1]);
				check_field("position", want.pos, m_tdata[14:2]);
				check_field("is_running", want.running, m_tdata[15]);
				check_field("steps_remaining", want.steps_left, m_tdata[39:16]);
				check_field("jog_done", want.jog_done, m_tdata[40]);
				check_field("aim_distance", want.aim_dist, m_tdata[52:41]);
			end
			results_seen++;
		end
	end

	// Receiver readiness, redrawn every cycle.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Ends a run that stops moving in either direction.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL stepper_jog_pulse_controller_unit");
			$finish;
		end
	end

	initial begin
		arst_n    = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_MIN_SPEED;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b0;

		lim_min      = MIN_SPEED_RST;
		lim_max      = MAX_SPEED_RST;
		mdl_running  = 1'b0;
		mdl_cw       = 1'b1;
		mdl_interval = '0;
		mdl_elapsed  = '0;
		mdl_jog_left = '0;
		mdl_pos      = '0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_fast_stepping();
		test_sender_gaps();
		test_receiver_stalls();
		test_crossed_limits();
		test_zero_limits();
		test_reset_limits();

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("PASS stepper_jog_pulse_controller_unit");
		end else begin
			$display("FAIL stepper_jog_pulse_controller_unit");
		end
		$finish;
	end

endmodule
